// ===== sv/sorted_alarm_queue_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Sorted alarm queue assertion macros
// Shared concurrent assertion forms for the alarm queue RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_ALARM_QUEUE_UNIT_MACROS_SVH
`define SORTED_ALARM_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SAQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SAQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/saq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted alarm queue package
// Types, codes and sizes shared by the alarm queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package saq_pkg;

   localparam int unsigned ALARM_SLOTS = 16;
   localparam int unsigned ID_W        = 4;
   localparam int unsigned TIME_W      = 64;
   localparam int unsigned NOW_W       = 63;
   localparam int unsigned LOAD_W      = 31;
   localparam int unsigned STEP_W      = 7;
   localparam logic [LOAD_W-1:0] LOAD_MAX = 31'h7fffffff;

   typedef enum logic [1:0] {
      CMD_ONESHOT  = 2'd0,
      CMD_PERIODIC = 2'd1,
      CMD_CANCEL   = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  command;
      logic [ID_W-1:0]          alarm_id;
      logic [NOW_W-1:0]         now;
      logic signed [TIME_W-1:0] time_value;
      logic [NOW_W-1:0]         interval;
   } req_type;

   typedef struct packed {
      logic              fired;
      logic [ID_W-1:0]   fired_id;
      logic              timer_write;
      logic [LOAD_W-1:0] timer_load;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] fire;
      logic [NOW_W-1:0]  period;
      logic [TIME_W-1:0] start;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_DROP,
      CELL_PACK,
      CELL_POP,
      CELL_PUSH
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   key;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PACK,
      ST_FIRE,
      ST_DIV,
      ST_PUSH,
      ST_LOAD,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/saq_rem_unit.sv =====
// ---------------------------------------------------------------------------
// Alarm queue remainder unit
// Restoring division, one quotient bit per cycle, remainder only.
// ---------------------------------------------------------------------------
`default_nettype none

module saq_rem_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [saq_pkg::TIME_W-1:0]     dividend,
   input  wire logic [saq_pkg::NOW_W-1:0]      divisor,
   output logic                                done,
   output logic [saq_pkg::NOW_W-1:0]           remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [saq_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [saq_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [saq_pkg::TIME_W-1:0]    dvd_ff, dvd_in;
   logic [saq_pkg::NOW_W-1:0]     dvs_ff, dvs_in;
   logic [saq_pkg::TIME_W-1:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[saq_pkg::TIME_W-2:0], dvd_ff[saq_pkg::TIME_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // subtract when the shifted remainder reaches the divisor
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[saq_pkg::TIME_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == saq_pkg::STEP_W'(saq_pkg::TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[saq_pkg::NOW_W-1:0];

endmodule

`default_nettype wire

// ===== sv/saq_cell.sv =====
// ---------------------------------------------------------------------------
// Alarm queue cell
// One place of the sorted list; trades entries with its neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module saq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire saq_pkg::cell_cmd_type cmd,
   input  wire saq_pkg::entry_type    prev_entry,
   input  wire logic                  prev_gt,
   input  wire saq_pkg::entry_type    next_entry,
   output saq_pkg::entry_type         entry,
   output logic                       gt
);

   saq_pkg::entry_type entry_ff, entry_in;

   // new key goes before this entry (or this place is empty)
   assign gt = !entry_ff.valid || ($signed(cmd.key.fire) < $signed(entry_ff.fire));

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         saq_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         saq_pkg::CELL_DROP: begin
            if (entry_ff.valid && entry_ff.id == cmd.key.id) begin
               entry_in.valid = 1'b0;
            end
         end
         saq_pkg::CELL_PACK: begin
            // pull a hole's successor up, leave a hole behind
            if (!entry_ff.valid) begin
               entry_in = next_entry;
            end else if (!prev_entry.valid) begin
               entry_in.valid = 1'b0;
            end
         end
         saq_pkg::CELL_POP: begin
            entry_in = next_entry;
         end
         saq_pkg::CELL_PUSH: begin
            if (prev_gt) begin
               entry_in = prev_entry;
            end else if (gt) begin
               entry_in = cmd.key;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== sv/sorted_alarm_queue_unit.sv =====
// Tick path: DECODE, then DONE (empty list) or LOAD; a periodic re-arm adds FIRE, PUSH.
// Set/cancel: drop plus compaction sweep, then FIRE (periodic), PUSH (set), LOAD, DONE.
// A past periodic start adds ST_DIV: 64 remainder steps before the push.
// Flow: one transaction at a time; req_ready returns together with rsp_valid.
// Reset: synchronous, empties the list; no clearing pass.
// ---------------------------------------------------------------------------
// Sorted alarm queue unit
// Alarm slots kept in a chain of cells sorted by fire time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sorted_alarm_queue_unit_macros.svh"

module sorted_alarm_queue_unit #(
   parameter int unsigned ALARM_SLOTS = saq_pkg::ALARM_SLOTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire saq_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output saq_pkg::rsp_type      rsp_payload
);

   localparam int unsigned CNT_W = $clog2(ALARM_SLOTS);

   // cell chain: index 0 is the head of the queue
   saq_pkg::entry_type    cell_q [ALARM_SLOTS];
   logic                  cell_gt [ALARM_SLOTS];
   saq_pkg::cell_cmd_type cell_cmd;

   saq_pkg::state_type state_ff, state_in;
   saq_pkg::req_type   req_ff, req_in;
   saq_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               fired_ff, fired_in;
   logic [saq_pkg::ID_W-1:0]   fired_id_ff, fired_id_in;
   logic               write_ff, write_in;
   logic [saq_pkg::LOAD_W-1:0] load_ff, load_in;
   logic               chk_head_ff, chk_head_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   saq_pkg::entry_type key_ff, key_in;

   // remainder unit
   logic                        rem_start;
   logic                        rem_done;
   logic [saq_pkg::NOW_W-1:0]   rem_value;
   logic [saq_pkg::TIME_W-1:0]  now_ext;

   // head views
   logic                        head_due;
   logic                        head_past;
   logic [saq_pkg::TIME_W-1:0]  head_diff;
   logic [saq_pkg::LOAD_W-1:0]  head_load;
   logic                        id_ok;

   genvar gi;
   generate
      for (gi = 0; gi < ALARM_SLOTS; gi++) begin : g_cell
         saq_pkg::entry_type prev_e;
         saq_pkg::entry_type next_e;
         logic               prev_g;
         if (gi == 0) begin : g_first
            always_comb begin
               prev_e       = '0;
               prev_e.valid = 1'b1;
               prev_g       = 1'b0;
            end
         end else begin : g_mid
            assign prev_e = cell_q[gi-1];
            assign prev_g = cell_gt[gi-1];
         end
         if (gi == ALARM_SLOTS - 1) begin : g_last
            assign next_e = '0;
         end else begin : g_inner
            assign next_e = cell_q[gi+1];
         end
         saq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cell_cmd),
            .prev_entry (prev_e),
            .prev_gt    (prev_g),
            .next_entry (next_e),
            .entry      (cell_q[gi]),
            .gt         (cell_gt[gi])
         );
      end
   endgenerate

   saq_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (now_ext - key_ff.start),
      .divisor   (key_ff.period),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign now_ext = {1'b0, req_ff.now};
   assign id_ok   = (9'(req_ff.alarm_id) < 9'(ALARM_SLOTS));

   // head is due when now is not below its fire time
   assign head_due  = !($signed(now_ext) < $signed(cell_q[0].fire));
   // saturate fire minus now into the countdown range
   assign head_past = cell_q[0].fire[saq_pkg::TIME_W-1] || (cell_q[0].fire < now_ext);
   assign head_diff = cell_q[0].fire - now_ext;
   always_comb begin
      if (head_past) begin
         head_load = '0;
      end else if (head_diff[saq_pkg::TIME_W-1:saq_pkg::LOAD_W] != '0) begin
         head_load = saq_pkg::LOAD_MAX;
      end else begin
         head_load = head_diff[saq_pkg::LOAD_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      fired_in     = fired_ff;
      fired_id_in  = fired_id_ff;
      write_in     = write_ff;
      load_in      = load_ff;
      chk_head_in  = chk_head_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      cell_cmd.op  = saq_pkg::CELL_HOLD;
      cell_cmd.key = key_ff;
      rem_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         saq_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_payload;
               fired_in    = 1'b0;
               fired_id_in = '0;
               write_in    = 1'b0;
               load_in     = '0;
               chk_head_in = 1'b0;
               state_in    = saq_pkg::ST_DECODE;
            end
         end
         saq_pkg::ST_DECODE: begin
            key_in.valid = 1'b1;
            key_in.id    = req_ff.alarm_id;
            if (req_ff.command == saq_pkg::CMD_TICK) begin
               if (!cell_q[0].valid) begin
                  state_in = saq_pkg::ST_DONE;
               end else if (!head_due) begin
                  chk_head_in = 1'b1;
                  state_in    = saq_pkg::ST_LOAD;
               end else begin
                  // pop the due head; keep it for a periodic re-arm
                  cell_cmd.op = saq_pkg::CELL_POP;
                  fired_in    = 1'b1;
                  fired_id_in = cell_q[0].id;
                  chk_head_in = 1'b1;
                  key_in      = cell_q[0];
                  if (cell_q[0].period != '0) begin
                     state_in = saq_pkg::ST_FIRE;
                  end else begin
                     state_in = saq_pkg::ST_LOAD;
                  end
               end
            end else if (!id_ok) begin
               state_in = saq_pkg::ST_DONE;
            end else begin
               // drop any live entry of this slot, then close the hole
               cell_cmd.op     = saq_pkg::CELL_DROP;
               cell_cmd.key.id = req_ff.alarm_id;
               chk_head_in     = cell_q[0].valid && (cell_q[0].id == req_ff.alarm_id);
               cnt_in          = '0;
               state_in        = saq_pkg::ST_PACK;
            end
         end
         saq_pkg::ST_PACK: begin
            cell_cmd.op = saq_pkg::CELL_PACK;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ALARM_SLOTS - 1)) begin
               unique case (req_ff.command)
                  saq_pkg::CMD_ONESHOT: begin
                     key_in.period = '0;
                     key_in.fire   = now_ext + req_ff.time_value;
                     state_in      = saq_pkg::ST_PUSH;
                  end
                  saq_pkg::CMD_PERIODIC: begin
                     key_in.period = req_ff.interval;
                     key_in.start  = req_ff.time_value;
                     state_in      = saq_pkg::ST_FIRE;
                  end
                  default: begin
                     state_in = saq_pkg::ST_LOAD;
                  end
               endcase
            end
         end
         saq_pkg::ST_FIRE: begin
            if (key_ff.period == '0) begin
               key_in.fire = '0;
               state_in    = saq_pkg::ST_PUSH;
            end else if ($signed(key_ff.start) < $signed(now_ext)) begin
               rem_start = 1'b1;
               state_in  = saq_pkg::ST_DIV;
            end else begin
               key_in.fire = key_ff.start;
               state_in    = saq_pkg::ST_PUSH;
            end
         end
         saq_pkg::ST_DIV: begin
            // next boundary after now: now - (now - start) mod period + period
            if (rem_done) begin
               key_in.fire = now_ext - {1'b0, rem_value} + {1'b0, key_ff.period};
               state_in    = saq_pkg::ST_PUSH;
            end
         end
         saq_pkg::ST_PUSH: begin
            cell_cmd.op = saq_pkg::CELL_PUSH;
            if (cell_gt[0]) begin
               chk_head_in = 1'b1;
            end
            state_in = saq_pkg::ST_LOAD;
         end
         saq_pkg::ST_LOAD: begin
            if (chk_head_ff && cell_q[0].valid) begin
               write_in = 1'b1;
               load_in  = head_load;
            end
            state_in = saq_pkg::ST_DONE;
         end
         saq_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.fired       = fired_ff;
               rsp_in.fired_id    = fired_id_ff;
               rsp_in.timer_write = write_ff;
               rsp_in.timer_load  = load_ff;
               rsp_valid_in       = 1'b1;
               state_in           = saq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = saq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= saq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      fired_ff    <= fired_in;
      fired_id_ff <= fired_id_in;
      write_ff    <= write_in;
      load_ff     <= load_in;
      chk_head_ff <= chk_head_in;
      cnt_ff      <= cnt_in;
      key_ff      <= key_in;
   end

   assign req_ready   = (state_ff == saq_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SAQ_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == saq_pkg::ST_DECODE, "accepted transaction did not reach decode")
   `SAQ_ASSERT_NOW(a_fired_id_zero, clock, reset, rsp_valid && !rsp_payload.fired, rsp_payload.fired_id == '0, "fired_id set without a fire")
   `SAQ_ASSERT_NOW(a_load_zero, clock, reset, rsp_valid && !rsp_payload.timer_write, rsp_payload.timer_load == '0, "timer_load set without a write")
   `SAQ_ASSERT_NEXT(a_div_push, clock, reset, state_ff == saq_pkg::ST_DIV && rem_done, state_ff == saq_pkg::ST_PUSH, "remainder result not consumed")

endmodule

`default_nettype wire
